FILE: rtl/ctcr_pkg.sv
// ---------------------------------------------------------------------------
// ctcr_pkg
// Shared types, widths and codes of the circle against tile map push-out block.
// ---------------------------------------------------------------------------
`default_nettype none

package ctcr_pkg;

   // Map dimensions
   localparam int MAX_MAP_WIDTH  = 64;
   localparam int MAX_MAP_HEIGHT = 64;
   localparam int MAP_CELLS      = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
   localparam int ADDR_W         = $clog2(MAP_CELLS);
   localparam int CELLX_W        = $clog2(MAX_MAP_WIDTH);
   localparam int CELLY_W        = $clog2(MAX_MAP_HEIGHT);
   localparam int DIMX_W         = $clog2(MAX_MAP_WIDTH + 1);
   localparam int DIMY_W         = $clog2(MAX_MAP_HEIGHT + 1);

   // Field widths
   localparam int CFG_W       = 7;
   localparam int CSR_ADDR_W  = 1;
   localparam int INDEX_W     = 12;
   localparam int Q_W16       = 16;
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 40;

   // Cell coordinates of the search box before clamping stay within +/-1024.
   localparam int BOX_W = 11;
   localparam logic signed [BOX_W-1:0] BOX_BEFORE = 11'sd1;
   localparam logic signed [BOX_W-1:0] BOX_AFTER  = 11'sd3;

   // Internal position, push-out magnitudes, root and quotient widths
   localparam int POS_W      = 26;
   localparam int MAG_W      = 25;
   localparam int SQ_W       = 2 * MAG_W + 1;
   localparam int ROOT_W     = 26;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int DVD_W      = MAG_W + Q_W16;
   localparam int QUOT_W     = Q_W16;
   localparam logic signed [POS_W:0] POS_LIMIT = 27'sd16777216;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MAP_WIDTH  = 1'b0,
      REG_MAP_HEIGHT = 1'b1
   } ctcr_reg_type;

   typedef enum logic {
      FUNC_TILE = 1'b0,
      FUNC_MOVE = 1'b1
   } ctcr_func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INTEG,
      ST_BOX,
      ST_READ,
      ST_WAIT,
      ST_EX,
      ST_SQ,
      ST_SUM,
      ST_SQRT,
      ST_OV,
      ST_DIV,
      ST_UPD,
      ST_DONE
   } ctcr_state_type;

endpackage

`default_nettype wire

FILE: rtl/ctcr_ram.sv
// ---------------------------------------------------------------------------
// ctcr_ram
// Generic single write port, single read port RAM with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ctcr_isqrt.sv
// ---------------------------------------------------------------------------
// ctcr_isqrt
// Iterative floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcr_isqrt import ctcr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_STEPS + 1);
   localparam logic [SQ_W-1:0] ONE_INIT = SQ_W'(1) << (2 * ROOT_STEPS - 2);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]  res_ff, res_in;
   logic [SQ_W-1:0]  one_ff, one_in;
   logic [SQ_W-1:0]  trial;

   always_comb begin
      trial   = res_ff + one_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_STEPS);
         rem_in  = radicand;
         res_in  = '0;
         one_in  = ONE_INIT;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/ctcr_div.sv
// ---------------------------------------------------------------------------
// ctcr_div
// Restoring divider, one quotient bit per cycle, for the push-out length.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcr_div import ctcr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [ROOT_W-1:0] divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   // The caller guarantees the quotient fits, so the divisor starts at the
   // weight of the top quotient bit.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = dividend;
         dsh_in  = DVD_W'(divisor) << (QUOT_W - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/circle_tile_collision_resolve_top.sv
// ---------------------------------------------------------------------------
// circle_tile_collision_resolve_top
// Tile map store and circle push-out sequencer.
// ---------------------------------------------------------------------------
// After reset the block clears the tile map, one tile a cycle, and takes no
// request until that is done. A move request integrates the position and sets
// up the search box, then reads each tile of the search box (one map read and
// its registered data); each blocking tile runs the 26-step square root, and
// each one that pushes also the 16-step divider, which work out the push. One
// request is worked on at a time, and the next one is taken while the result
// waits on the response side.
`default_nettype none

module circle_tile_collision_resolve_top import ctcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // tdata, from bit 0: tile_index[12], tile_blocked[1], pos_x[16], pos_y[16],
   // vel_x[16], vel_y[16], dt_step[16], use_full_step[1], radius[16], zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,   // func
   // tdata, from bit 0: new_pos_x[16], new_pos_y[16], hit[1], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   ctcr_state_type state_ff, state_in;

   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [CFG_W-1:0]           width_ff, width_in;
   logic [CFG_W-1:0]           height_ff, height_in;

   logic signed [Q_W16-1:0]    px_ff, px_in, py_ff, py_in;
   logic signed [Q_W16-1:0]    vx_ff, vx_in, vy_ff, vy_in;
   logic [Q_W16-1:0]           dt_ff, dt_in;
   logic                       full_ff, full_in;
   logic [Q_W16-1:0]           rad_ff, rad_in;
   logic signed [POS_W-1:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic                       hit_ff, hit_in;
   logic [CELLX_W-1:0]         left_ff, left_in, right_ff, right_in, tx_ff, tx_in;
   logic [CELLY_W-1:0]         bottom_ff, bottom_in, ty_ff, ty_in;
   logic [MAG_W-1:0]           ax_ff, ax_in, ay_ff, ay_in;
   logic                       sx_ff, sx_in, sy_ff, sy_in;
   logic                       nz_ff, nz_in;
   logic [2*MAG_W-1:0]         sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [Q_W16-1:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                       rsp_hit_ff, rsp_hit_in;

   // Control decode
   logic                       req_acc;
   logic                       out_free;
   logic                       out_load;
   logic                       adv;
   logic                       last_tile;
   logic                       push;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic                       ram_wdata;
   logic [ADDR_W-1:0]          ram_raddr;
   logic                       ram_rdata;
   logic                       sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]          root;
   logic                       div_start, divx_done, divy_done;
   logic [QUOT_W-1:0]          qx, qy;
   logic [DVD_W-1:0]           dvd_x, dvd_y;
   logic [SQ_W-1:0]            radicand;

   // Clamped map size
   logic [DIMX_W-1:0]          wc;
   logic [DIMY_W-1:0]          hc;

   // Search box
   logic signed [BOX_W-1:0]    ccx, ccy, tcx, tcy;
   logic signed [BOX_W-1:0]    left_c, right_c, top_c, bottom_c;
   logic signed [18:0]         nq_x, nq_y;
   logic                       box_empty;

   // Integration and push-out arithmetic
   logic signed [33:0]         prod_x, prod_y;
   logic signed [17:0]         disp_x, disp_y;
   logic signed [POS_W:0]      tlo_x, thi_x, tlo_y, thi_y, nxe, nye, cx, cy, ex, ey;
   logic signed [ROOT_W:0]     ov;
   logic signed [POS_W:0]      upd_x, upd_y;
   logic [ADDR_W:0]            lin_addr;
   logic [REQ_DATA_W-1:0]      rd;

   assign rd = req_tdata;

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (ctcr_reg_type'(csr_addr))
            REG_MAP_WIDTH:  width_in  = csr_wdata;
            REG_MAP_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      wc = (10'(width_ff) > 10'(MAX_MAP_WIDTH)) ? DIMX_W'(MAX_MAP_WIDTH) : DIMX_W'(width_ff);
      hc = (10'(height_ff) > 10'(MAX_MAP_HEIGHT)) ?
           DIMY_W'(MAX_MAP_HEIGHT) : DIMY_W'(height_ff);
   end

   // ---------------------------------------------------------------------
   // Shared arithmetic
   // ---------------------------------------------------------------------
   always_comb begin
      prod_x = 34'(vx_ff) * 34'($signed({1'b0, dt_ff}));
      prod_y = 34'(vy_ff) * 34'($signed({1'b0, dt_ff}));
      disp_x = full_ff ? 18'(vx_ff) : prod_x[33:16];
      disp_y = full_ff ? 18'(vy_ff) : prod_y[33:16];

      // Current cell rounds down, target cell rounds toward zero.
      ccx  = BOX_W'(px_ff >>> 8);
      ccy  = BOX_W'(py_ff >>> 8);
      nq_x = 19'(nx_ff) + ((nx_ff < 0) ? 19'sd255 : 19'sd0);
      nq_y = 19'(ny_ff) + ((ny_ff < 0) ? 19'sd255 : 19'sd0);
      tcx  = BOX_W'(nq_x >>> 8);
      tcy  = BOX_W'(nq_y >>> 8);

      left_c   = ((ccx < tcx) ? ccx : tcx) - BOX_BEFORE;
      right_c  = ((ccx > tcx) ? ccx : tcx) + BOX_AFTER;
      top_c    = ((ccy < tcy) ? ccy : tcy) - BOX_BEFORE;
      bottom_c = ((ccy > tcy) ? ccy : tcy) + BOX_AFTER;
      if (left_c < 0) begin
         left_c = '0;
      end
      if (top_c < 0) begin
         top_c = '0;
      end
      if (right_c > BOX_W'($signed({1'b0, wc})) - 11'sd1) begin
         right_c = BOX_W'($signed({1'b0, wc})) - 11'sd1;
      end
      if (bottom_c > BOX_W'($signed({1'b0, hc})) - 11'sd1) begin
         bottom_c = BOX_W'($signed({1'b0, hc})) - 11'sd1;
      end
      box_empty = (left_c > right_c) || (top_c > bottom_c);

      lin_addr = (ADDR_W+1)'(ty_ff) * (ADDR_W+1)'(wc) + (ADDR_W+1)'(tx_ff);

      // Nearest point of the tile square and the vector to it
      tlo_x = $signed((POS_W+1)'({tx_ff, 8'b0}));
      thi_x = tlo_x + 27'sd256;
      tlo_y = $signed((POS_W+1)'({ty_ff, 8'b0}));
      thi_y = tlo_y + 27'sd256;
      nxe   = (POS_W+1)'(nx_ff);
      nye   = (POS_W+1)'(ny_ff);
      cx    = (nxe < tlo_x) ? tlo_x : ((nxe > thi_x) ? thi_x : nxe);
      cy    = (nye < tlo_y) ? tlo_y : ((nye > thi_y) ? thi_y : nye);
      ex    = cx - nxe;
      ey    = cy - nye;

      radicand = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
      ov       = $signed((ROOT_W+1)'(rad_ff)) - $signed((ROOT_W+1)'(root));
      push     = nz_ff && (ov > 0);
      dvd_x    = DVD_W'(ax_ff) * DVD_W'(ov[Q_W16-1:0]);
      dvd_y    = DVD_W'(ay_ff) * DVD_W'(ov[Q_W16-1:0]);

      upd_x = sx_ff ? (nxe + (POS_W+1)'(qx)) : (nxe - (POS_W+1)'(qx));
      upd_y = sy_ff ? (nye + (POS_W+1)'(qy)) : (nye - (POS_W+1)'(qy));
      if (upd_x > POS_LIMIT) begin
         upd_x = POS_LIMIT;
      end else if (upd_x < -POS_LIMIT) begin
         upd_x = -POS_LIMIT;
      end
      if (upd_y > POS_LIMIT) begin
         upd_y = POS_LIMIT;
      end else if (upd_y < -POS_LIMIT) begin
         upd_y = -POS_LIMIT;
      end

      last_tile = (tx_ff == right_ff) && (ty_ff == bottom_ff);
      adv = ((state_ff == ST_WAIT) && !ram_rdata) ||
            ((state_ff == ST_OV) && !push) ||
            (state_ff == ST_UPD);
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(MAP_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (ctcr_func_type'(req_tuser) == FUNC_TILE) ? ST_DONE : ST_INTEG;
            end
         end
         ST_INTEG: state_in = ST_BOX;
         ST_BOX:   state_in = box_empty ? ST_DONE : ST_READ;
         ST_READ:  state_in = ST_WAIT;
         ST_WAIT:  state_in = ram_rdata ? ST_EX : (last_tile ? ST_DONE : ST_READ);
         ST_EX:    state_in = ST_SQ;
         ST_SQ:    state_in = ST_SUM;
         ST_SUM:   state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_OV;
            end
         end
         ST_OV:    state_in = push ? ST_DIV : (last_tile ? ST_DONE : ST_READ);
         ST_DIV: begin
            if (divx_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD:   state_in = last_tile ? ST_DONE : ST_READ;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      req_acc    = req_tvalid && req_tready;
      out_free   = !rsp_valid_ff || rsp_tready;
      out_load   = (state_ff == ST_DONE) && out_free;
      sqrt_start = (state_ff == ST_SUM);
      div_start  = (state_ff == ST_OV) && push;
      ram_raddr  = lin_addr[ADDR_W-1:0];
      ram_we     = 1'b0;
      ram_waddr  = clr_addr_ff;
      ram_wdata  = 1'b0;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
      end else if (req_acc && (ctcr_func_type'(req_tuser) == FUNC_TILE)) begin
         ram_we    = ({1'b0, rd[INDEX_W-1:0]} < (INDEX_W+1)'(MAP_CELLS));
         ram_waddr = ADDR_W'(rd[INDEX_W-1:0]);
         ram_wdata = rd[12];
      end
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      dt_in        = dt_ff;
      full_in      = full_ff;
      rad_in       = rad_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      hit_in       = hit_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      bottom_in    = bottom_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      nz_in        = nz_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + 1'b1;
         ST_IDLE: begin
            if (req_acc) begin
               px_in   = rd[28:13];
               py_in   = rd[44:29];
               vx_in   = rd[60:45];
               vy_in   = rd[76:61];
               dt_in   = rd[92:77];
               full_in = rd[93];
               rad_in  = rd[109:94];
               nx_in   = '0;
               ny_in   = '0;
               hit_in  = 1'b0;
            end
         end
         ST_INTEG: begin
            nx_in = POS_W'(px_ff) + POS_W'(disp_x);
            ny_in = POS_W'(py_ff) + POS_W'(disp_y);
         end
         ST_BOX: begin
            left_in   = CELLX_W'(left_c);
            right_in  = CELLX_W'(right_c);
            bottom_in = CELLY_W'(bottom_c);
            tx_in     = CELLX_W'(left_c);
            ty_in     = CELLY_W'(top_c);
         end
         ST_EX: begin
            sx_in = (ex < 0);
            sy_in = (ey < 0);
            ax_in = MAG_W'((ex < 0) ? -ex : ex);
            ay_in = MAG_W'((ey < 0) ? -ey : ey);
            nz_in = (ex != 0) || (ey != 0);
         end
         ST_SQ: begin
            sqx_in = ax_ff * ax_ff;
            sqy_in = ay_ff * ay_ff;
         end
         ST_UPD: begin
            nx_in  = POS_W'(upd_x);
            ny_in  = POS_W'(upd_y);
            hit_in = 1'b1;
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               if (nx_ff > 26'sd32767) begin
                  rsp_x_in = 16'sh7FFF;
               end else if (nx_ff < -26'sd32768) begin
                  rsp_x_in = 16'sh8000;
               end else begin
                  rsp_x_in = Q_W16'(nx_ff);
               end
               if (ny_ff > 26'sd32767) begin
                  rsp_y_in = 16'sh7FFF;
               end else if (ny_ff < -26'sd32768) begin
                  rsp_y_in = 16'sh8000;
               end else begin
                  rsp_y_in = Q_W16'(ny_ff);
               end
            end
         end
         default: ;
      endcase

      // Step along the row, then down to the next row.
      if (adv) begin
         if (tx_ff == right_ff) begin
            tx_in = left_ff;
            ty_in = ty_ff + 1'b1;
         end else begin
            tx_in = tx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         width_ff     <= CFG_W'(64);
         height_ff    <= CFG_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff      <= px_in;
      py_ff      <= py_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      dt_ff      <= dt_in;
      full_ff    <= full_in;
      rad_ff     <= rad_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      hit_ff     <= hit_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      bottom_ff  <= bottom_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      nz_ff      <= nz_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_hit_ff, rsp_y_ff, rsp_x_ff});

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   ctcr_ram #(
      .WIDTH (1),
      .DEPTH (MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ctcr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   ctcr_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_x),
      .divisor  (root),
      .done     (divx_done),
      .quotient (qx)
   );

   ctcr_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_y),
      .divisor  (root),
      .done     (divy_done),
      .quotient (qy)
   );

`ifndef ASSERT_OFF
   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during the map clearing pass");

   a_map_write_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_IDLE)))
      else $error("tile map written during a move");

   a_read_inside_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((tx_ff <= right_ff) && (ty_ff <= bottom_ff)))
      else $error("tile read outside the search box");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> ((nx_ff <= POS_LIMIT) && (nx_ff >= -POS_LIMIT) &&
                                (ny_ff <= POS_LIMIT) && (ny_ff >= -POS_LIMIT)))
      else $error("pushed position beyond its limit");

   a_dividers_in_step: assert property (@(posedge clock) disable iff (reset)
      (divx_done == divy_done) && (!sqrt_done || (state_ff == ST_SQRT)))
      else $error("root or divider finished out of sequence");
`endif

endmodule

`default_nettype wire
